// ===== src/cac_pkg.sv =====
// Shared constants, operation codes and pipeline control type of the complex arithmetic unit
package cac_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    typedef struct packed {
        logic valid;
        logic div;
        logic mul;
        logic is_real;
        logic fb;
        logic neg_re;
        logic neg_im;
        logic big_re;
        logic big_im;
    } ctl_t;

endpackage

// ===== src/cac_front.sv =====
// Front end: products, sums and magnitude set-up ahead of the divider chain
module cac_front #(
    parameter int W = 32,
    parameter int F = 16,
    parameter int X = 97
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [1:0]          mode,
    input  logic signed [W-1:0] a_re,
    input  logic signed [W-1:0] a_im,
    input  logic                a_is_real,
    input  logic signed [W-1:0] b_re,
    input  logic signed [W-1:0] b_im,
    input  logic                b_is_real,
    output logic [X-1:0]        r_re,
    output logic [X-1:0]        r_im,
    output logic [X-1:0]        d,
    output cac_pkg::ctl_t       ctl
);
    import cac_pkg::*;

    localparam int S = 2 * W + 2;
    localparam int M = 2 * W + 1;

    // stage 1 registers
    logic                  v1_reg;
    op_t                   op1_reg;
    logic                  real1_reg, bzero1_reg;
    logic signed [W-1:0]   ar_reg, ai_reg, br_reg, bi_reg;
    logic signed [2*W-1:0] p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg, p_bb_reg, p_jj_reg;
    logic signed [W-1:0]   ai_next, bi_next;

    // stage 2 registers
    ctl_t                  c2_reg, c2_next;
    logic signed [S-1:0]   re2_reg, im2_reg, re2_next, im2_next;
    logic [M-1:0]          den2_reg, den2_next;

    // stage 3 registers
    ctl_t                  c3_reg, c3_next;
    logic [X-1:0]          r_re_reg, r_im_reg, d_reg, r_re_next, r_im_next, d_next;

    logic signed [S-1:0]   e_rr, e_ii, e_ri, e_ir, e_ar, e_ai, e_br, e_bi;
    logic [S-1:0]          den_full, mag_re_full, mag_im_full;
    logic [X-1:0]          mag_re_x, mag_im_x;

    assign ai_next = a_is_real ? '0 : a_im;
    assign bi_next = b_is_real ? '0 : b_im;

    // hold control of each stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            c2_reg <= '0;
            c3_reg <= '0;
        end
        else
        begin
            v1_reg <= in_valid;
            c2_reg <= c2_next;
            c3_reg <= c3_next;
        end
    end

    // advance payload of every stage: operands, all six products, sums and scaled magnitudes
    always_ff @(posedge clk)
    begin
        op1_reg    <= op_t'(mode);
        real1_reg  <= a_is_real & b_is_real;
        bzero1_reg <= b_is_real & (b_re == '0);
        ar_reg     <= a_re;
        ai_reg     <= ai_next;
        br_reg     <= b_re;
        bi_reg     <= bi_next;
        p_rr_reg   <= a_re * b_re;
        p_ii_reg   <= ai_next * bi_next;
        p_ri_reg   <= a_re * bi_next;
        p_ir_reg   <= ai_next * b_re;
        p_bb_reg   <= b_re * b_re;
        p_jj_reg   <= bi_next * bi_next;
        re2_reg    <= re2_next;
        im2_reg    <= im2_next;
        den2_reg   <= den2_next;
        r_re_reg   <= r_re_next;
        r_im_reg   <= r_im_next;
        d_reg      <= d_next;
    end

    // widen to a common signed size
    assign e_rr = {{(S-2*W){p_rr_reg[2*W-1]}}, p_rr_reg};
    assign e_ii = {{(S-2*W){p_ii_reg[2*W-1]}}, p_ii_reg};
    assign e_ri = {{(S-2*W){p_ri_reg[2*W-1]}}, p_ri_reg};
    assign e_ir = {{(S-2*W){p_ir_reg[2*W-1]}}, p_ir_reg};
    assign e_ar = {{(S-W){ar_reg[W-1]}}, ar_reg};
    assign e_ai = {{(S-W){ai_reg[W-1]}}, ai_reg};
    assign e_br = {{(S-W){br_reg[W-1]}}, br_reg};
    assign e_bi = {{(S-W){bi_reg[W-1]}}, bi_reg};
    assign den_full = {{(S-2*W){1'b0}}, p_bb_reg} + {{(S-2*W){1'b0}}, p_jj_reg};

    // combine products per operation
    always_comb
    begin
        c2_next         = '0;
        c2_next.valid   = v1_reg;
        c2_next.is_real = real1_reg;
        den2_next       = den_full[M-1:0];
        re2_next        = '0;
        im2_next        = '0;
        unique case (op1_reg)
            OP_ADD:
            begin
                re2_next = e_ar + e_br;
                im2_next = e_ai + e_bi;
            end
            OP_SUB:
            begin
                re2_next = e_ar - e_br;
                im2_next = e_ai - e_bi;
            end
            OP_MUL:
            begin
                c2_next.mul = 1'b1;
                re2_next    = e_rr - e_ii;
                im2_next    = e_ri + e_ir;
            end
            OP_DIV:
            begin
                if (bzero1_reg)
                begin
                    c2_next.fb = 1'b1;
                    re2_next   = e_ar;
                    im2_next   = e_ai;
                end
                else if (den_full == '0)
                begin
                    c2_next.fb = 1'b1;
                end
                else
                begin
                    c2_next.div = 1'b1;
                    re2_next    = e_rr + e_ii;
                    im2_next    = e_ir - e_ri;
                end
            end
            default:
            begin
                re2_next = '0;
            end
        endcase
    end

    // take magnitudes, scale and check quotient range
    assign mag_re_full = re2_reg[S-1] ? (~re2_reg + 1'b1) : re2_reg;
    assign mag_im_full = im2_reg[S-1] ? (~im2_reg + 1'b1) : im2_reg;
    assign mag_re_x    = {{(X-M){1'b0}}, mag_re_full[M-1:0]};
    assign mag_im_x    = {{(X-M){1'b0}}, mag_im_full[M-1:0]};

    always_comb
    begin
        c3_next        = c2_reg;
        c3_next.neg_re = re2_reg[S-1];
        c3_next.neg_im = im2_reg[S-1];
        d_next         = {{(X-M){1'b0}}, den2_reg} << W;
        r_re_next      = mag_re_x;
        r_im_next      = mag_im_x;
        if (c2_reg.mul)
        begin
            r_re_next = mag_re_x >> F;
            r_im_next = mag_im_x >> F;
        end
        else if (c2_reg.div)
        begin
            r_re_next = mag_re_x << F;
            r_im_next = mag_im_x << F;
        end
        c3_next.big_re = c2_reg.div & (r_re_next >= d_next);
        c3_next.big_im = c2_reg.div & (r_im_next >= d_next);
    end

    assign r_re = r_re_reg;
    assign r_im = r_im_reg;
    assign d    = d_reg;
    assign ctl  = c3_reg;

endmodule

// ===== src/cac_cell.sv =====
// Divider cell: one restoring quotient bit for both parts per cycle
module cac_cell #(
    parameter int W = 32,
    parameter int X = 97
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic [X-1:0]  r_re_in,
    input  logic [X-1:0]  r_im_in,
    input  logic [X-1:0]  d_in,
    input  logic [W-1:0]  q_re_in,
    input  logic [W-1:0]  q_im_in,
    input  cac_pkg::ctl_t ctl_in,
    output logic [X-1:0]  r_re_out,
    output logic [X-1:0]  r_im_out,
    output logic [X-1:0]  d_out,
    output logic [W-1:0]  q_re_out,
    output logic [W-1:0]  q_im_out,
    output cac_pkg::ctl_t ctl_out
);
    import cac_pkg::*;

    ctl_t         ctl_reg;
    logic [X-1:0] r_re_reg, r_im_reg, d_reg, r_re_next, r_im_next, d_half;
    logic [W-1:0] q_re_reg, q_im_reg, q_re_next, q_im_next;
    logic         ge_re, ge_im;

    assign d_half = d_in >> 1;
    assign ge_re  = r_re_in >= d_half;
    assign ge_im  = r_im_in >= d_half;

    // trial subtract when dividing, else pass through
    always_comb
    begin
        r_re_next = r_re_in;
        r_im_next = r_im_in;
        q_re_next = q_re_in;
        q_im_next = q_im_in;
        if (ctl_in.div)
        begin
            r_re_next = ge_re ? (r_re_in - d_half) : r_re_in;
            r_im_next = ge_im ? (r_im_in - d_half) : r_im_in;
            q_re_next = {q_re_in[W-2:0], ge_re};
            q_im_next = {q_im_in[W-2:0], ge_im};
        end
    end

    // hold control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl_in;
        end
    end

    // advance data to the next cell
    always_ff @(posedge clk)
    begin
        r_re_reg <= r_re_next;
        r_im_reg <= r_im_next;
        d_reg    <= d_half;
        q_re_reg <= q_re_next;
        q_im_reg <= q_im_next;
    end

    assign r_re_out = r_re_reg;
    assign r_im_out = r_im_reg;
    assign d_out    = d_reg;
    assign q_re_out = q_re_reg;
    assign q_im_out = q_im_reg;
    assign ctl_out  = ctl_reg;

endmodule

// ===== src/complex_arith_unit_top.sv =====
// Top level of the complex arithmetic unit: front end, divider cell chain and saturation
//
//  channel  | handshake          | payload
//  ---------+--------------------+-----------------------------------------------
//  command  | start / busy       | mode, a_re, a_im, a_is_real, b_re, b_im, b_is_real
//  result   | done (one cycle)   | out_re, out_im, out_is_real, div_zero_fallback, overflow
//
// One transaction enters every cycle; busy is always low.
// Each result passes through three front-end stages, one divider cell per
// quotient bit and one output register. All operations take the same path,
// so results leave in command order.
// Reset clears the valid bits of every stage; no results are lost to stalls
// because the receiver cannot stall.
module complex_arith_unit_top #(
    parameter int DATA_WIDTH = cac_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = cac_pkg::FRAC_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [1:0]                   mode,
    input  logic signed [DATA_WIDTH-1:0] a_re,
    input  logic signed [DATA_WIDTH-1:0] a_im,
    input  logic                         a_is_real,
    input  logic signed [DATA_WIDTH-1:0] b_re,
    input  logic signed [DATA_WIDTH-1:0] b_im,
    input  logic                         b_is_real,
    output logic                         done,
    output logic signed [DATA_WIDTH-1:0] out_re,
    output logic signed [DATA_WIDTH-1:0] out_im,
    output logic                         out_is_real,
    output logic                         div_zero_fallback,
    output logic                         overflow
);
    import cac_pkg::*;

    localparam int W  = DATA_WIDTH;
    localparam int M  = 2 * W + 1;
    localparam int SH = (W > FRAC_BITS) ? W : FRAC_BITS;
    localparam int X  = M + SH;
    localparam logic [X-1:0] LIM_NEG = {{(X-1){1'b0}}, 1'b1} << (W - 1);
    localparam logic [X-1:0] LIM_POS = LIM_NEG - 1'b1;

    logic [X-1:0] r_re_c [0:W];
    logic [X-1:0] r_im_c [0:W];
    logic [X-1:0] d_c    [0:W];
    logic [W-1:0] q_re_c [0:W];
    logic [W-1:0] q_im_c [0:W];
    ctl_t         ctl_c  [0:W];

    logic                done_reg;
    logic signed [W-1:0] out_re_reg, out_im_reg, sat_re, sat_im;
    logic                real_reg, fb_reg, ov_reg, ov_re, ov_im;
    logic [X-1:0]        val_re, val_im;
    ctl_t                ce;

    assign busy = 1'b0;

    cac_front #(.W(W), .F(FRAC_BITS), .X(X)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start),
        .mode      (mode),
        .a_re      (a_re),
        .a_im      (a_im),
        .a_is_real (a_is_real),
        .b_re      (b_re),
        .b_im      (b_im),
        .b_is_real (b_is_real),
        .r_re      (r_re_c[0]),
        .r_im      (r_im_c[0]),
        .d         (d_c[0]),
        .ctl       (ctl_c[0])
    );

    assign q_re_c[0] = '0;
    assign q_im_c[0] = '0;

    // chain of divider cells, one quotient bit each
    genvar gi;
    generate
        for (gi = 0; gi < W; gi++)
        begin : g_cell
            cac_cell #(.W(W), .X(X)) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .r_re_in  (r_re_c[gi]),
                .r_im_in  (r_im_c[gi]),
                .d_in     (d_c[gi]),
                .q_re_in  (q_re_c[gi]),
                .q_im_in  (q_im_c[gi]),
                .ctl_in   (ctl_c[gi]),
                .r_re_out (r_re_c[gi+1]),
                .r_im_out (r_im_c[gi+1]),
                .d_out    (d_c[gi+1]),
                .q_re_out (q_re_c[gi+1]),
                .q_im_out (q_im_c[gi+1]),
                .ctl_out  (ctl_c[gi+1])
            );
        end
    endgenerate

    // pick quotient or magnitude, then saturate
    assign ce     = ctl_c[W];
    assign val_re = ce.div ? {{(X-W){1'b0}}, q_re_c[W]} : r_re_c[W];
    assign val_im = ce.div ? {{(X-W){1'b0}}, q_im_c[W]} : r_im_c[W];

    always_comb
    begin
        if (!ce.neg_re)
        begin
            ov_re  = ce.big_re | (val_re > LIM_POS);
            sat_re = ov_re ? LIM_POS[W-1:0] : val_re[W-1:0];
        end
        else
        begin
            ov_re  = ce.big_re | (val_re > LIM_NEG);
            sat_re = ov_re ? LIM_NEG[W-1:0] : (~val_re[W-1:0] + 1'b1);
        end
        if (!ce.neg_im)
        begin
            ov_im  = ce.big_im | (val_im > LIM_POS);
            sat_im = ov_im ? LIM_POS[W-1:0] : val_im[W-1:0];
        end
        else
        begin
            ov_im  = ce.big_im | (val_im > LIM_NEG);
            sat_im = ov_im ? LIM_NEG[W-1:0] : (~val_im[W-1:0] + 1'b1);
        end
    end

    // hold result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= ce.valid;
        end
    end

    // register result transaction
    always_ff @(posedge clk)
    begin
        out_re_reg <= sat_re;
        out_im_reg <= ce.is_real ? '0 : sat_im;
        real_reg   <= ce.is_real;
        fb_reg     <= ce.fb;
        ov_reg     <= ov_re | (ov_im & ~ce.is_real);
    end

    assign done              = done_reg;
    assign out_re            = out_re_reg;
    assign out_im            = out_im_reg;
    assign out_is_real       = real_reg;
    assign div_zero_fallback = fb_reg;
    assign overflow          = ov_reg;

endmodule
